// ===== rtl/lowest_free_handle_table_defines.svh =====
// assertion macros for the handle table checker
`ifndef LOWEST_FREE_HANDLE_TABLE_DEFINES_SVH
`define LOWEST_FREE_HANDLE_TABLE_DEFINES_SVH

// condition in a cycle implies a consequence in the same cycle
`define LFHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in a cycle implies a consequence in the next cycle
`define LFHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfht_pkg.sv =====
// types and constants of the lowest-free handle table
`default_nettype none

package lfht_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int HANDLE_W    = 12;
    localparam int OBJ_W       = 16;
    localparam int STATUS_W    = 3;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_SET     = 2'd1,
        ACT_GET     = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_EMPTY = 3'd2,
        ST_FULL  = 3'd3,
        ST_NULL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_TEST,
        S_READ,
        S_CHECK,
        S_TRAIL_TEST,
        S_TRAIL_READ,
        S_TRAIL_CHECK,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/lowest_free_handle_table.sv =====
// lowest-free handle table: slot store, search sequencer and result register
//
// Input channel (in_valid/in_ready) takes one command item: action, handle_index,
// min_index, object_id. Output channel (out_valid/out_ready) returns one result
// item per command: status, result_index, found_object, released_object,
// ref_taken, used_count.
// Only one command is worked on at a time; in_ready is high while the sequencer
// is idle. The slot store is a single-port memory with a registered read.
// Steps from accept to result valid:
//   get, set, release of a non-trailing slot: read the slot, check it, finish
//   allocate: test, read and check each occupied slot from the start point; an
//     append or a full table is decided in the test step at the end mark
//   release of the last used slot: walk the end mark down over each trailing
//     empty slot (test, read, check) until a used slot or an empty table
//   range, null and early empty errors: straight to finish
// The result sits in an output register, so the next command is accepted while
// a result waits; if the receiver stalls, a finished command waits in place
// and in_ready stays low until the output register frees up.
// After reset a clearing pass writes every slot to empty with in_ready low;
// then the hint, end mark and used count start at zero.
`default_nettype none

module lowest_free_handle_table
    import lfht_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          action,
    input  wire logic [HANDLE_W-1:0] handle_index,
    input  wire logic [HANDLE_W-1:0] min_index,
    input  wire logic [OBJ_W-1:0]    object_id,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [IDX_W-1:0]         result_index,
    output logic [OBJ_W-1:0]         found_object,
    output logic [OBJ_W-1:0]         released_object,
    output logic                     ref_taken,
    output logic [CNT_W-1:0]         used_count
);

    state_t state_reg, state_next;
    action_t act_reg, act_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [OBJ_W-1:0] obj_reg, obj_next;
    logic [CNT_W-1:0] hint_reg, hint_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] count_reg, count_next;

    status_t pend_status_reg, pend_status_next;
    logic [IDX_W-1:0] pend_index_reg, pend_index_next;
    logic [OBJ_W-1:0] pend_found_reg, pend_found_next;
    logic [OBJ_W-1:0] pend_released_reg, pend_released_next;
    logic pend_ref_reg, pend_ref_next;

    logic out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic [OBJ_W-1:0] out_found_reg, out_found_next;
    logic [OBJ_W-1:0] out_released_reg, out_released_next;
    logic out_ref_reg, out_ref_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    logic [OBJ_W-1:0] mem [MAX_ENTRIES];
    logic [OBJ_W-1:0] rd_data_reg;
    logic mem_we;
    logic [OBJ_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_addr;

    logic [HANDLE_W-1:0] alloc_start;
    logic scan_done;
    logic rd_empty;

    assign alloc_start = (min_index > HANDLE_W'(hint_reg)) ? min_index
                                                           : HANDLE_W'(hint_reg);
    assign scan_done   = (idx_reg >= end_reg);
    assign rd_empty    = (rd_data_reg == '0);
    assign mem_addr    = idx_reg[IDX_W-1:0];

    // slot store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            hint_reg      <= '0;
            end_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hint_reg      <= hint_next;
            end_reg       <= end_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg           <= act_next;
        obj_reg           <= obj_next;
        pend_status_reg   <= pend_status_next;
        pend_index_reg    <= pend_index_next;
        pend_found_reg    <= pend_found_next;
        pend_released_reg <= pend_released_next;
        pend_ref_reg      <= pend_ref_next;
        out_status_reg    <= out_status_next;
        out_index_reg     <= out_index_next;
        out_found_reg     <= out_found_next;
        out_released_reg  <= out_released_next;
        out_ref_reg       <= out_ref_next;
        out_count_reg     <= out_count_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next         = state_reg;
        act_next           = act_reg;
        idx_next           = idx_reg;
        obj_next           = obj_reg;
        hint_next          = hint_reg;
        end_next           = end_reg;
        count_next         = count_reg;
        pend_status_next   = pend_status_reg;
        pend_index_next    = pend_index_reg;
        pend_found_next    = pend_found_reg;
        pend_released_next = pend_released_reg;
        pend_ref_next      = pend_ref_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_status_next    = out_status_reg;
        out_index_next     = out_index_reg;
        out_found_next     = out_found_reg;
        out_released_next  = out_released_reg;
        out_ref_next       = out_ref_reg;
        out_count_next     = out_count_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg[IDX_W-1:0] == '1)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next           = action_t'(action);
                    obj_next           = object_id;
                    pend_status_next   = ST_OK;
                    pend_index_next    = '0;
                    pend_found_next    = '0;
                    pend_released_next = '0;
                    pend_ref_next      = 1'b0;
                    idx_next           = handle_index[CNT_W-1:0];
                    unique case (action_t'(action))
                        ACT_ALLOC:
                        begin
                            idx_next = alloc_start[CNT_W-1:0];
                            if (object_id == '0)
                            begin
                                pend_status_next = ST_NULL;
                                state_next       = S_FINISH;
                            end
                            else if (alloc_start >= HANDLE_W'(MAX_ENTRIES))
                            begin
                                pend_status_next = ST_RANGE;
                                state_next       = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_ALLOC_TEST;
                            end
                        end
                        ACT_SET:
                        begin
                            if (object_id == '0)
                            begin
                                pend_status_next = ST_NULL;
                                state_next       = S_FINISH;
                            end
                            else if (handle_index >= HANDLE_W'(MAX_ENTRIES))
                            begin
                                pend_status_next = ST_RANGE;
                                state_next       = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        ACT_GET, ACT_RELEASE:
                        begin
                            if (handle_index >= HANDLE_W'(MAX_ENTRIES))
                            begin
                                pend_status_next = ST_RANGE;
                                state_next       = S_FINISH;
                            end
                            else if (handle_index >= HANDLE_W'(end_reg))
                            begin
                                pend_status_next = ST_EMPTY;
                                state_next       = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_ALLOC_TEST:
            begin
                if (!scan_done)
                begin
                    state_next = S_READ;
                end
                else if (idx_reg >= CNT_W'(MAX_ENTRIES))
                begin
                    pend_status_next = ST_FULL;
                    state_next       = S_FINISH;
                end
                else
                begin
                    // no hole below the end mark: append
                    hint_next       = idx_reg + 1'b1;
                    end_next        = idx_reg + 1'b1;
                    count_next      = count_reg + 1'b1;
                    pend_index_next = idx_reg[IDX_W-1:0];
                    pend_ref_next   = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_FINISH;
                unique case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (rd_empty)
                        begin
                            hint_next       = idx_reg + 1'b1;
                            count_next      = count_reg + 1'b1;
                            pend_index_next = idx_reg[IDX_W-1:0];
                            pend_ref_next   = 1'b1;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_ALLOC_TEST;
                        end
                    end
                    ACT_SET:
                    begin
                        if (idx_reg == hint_reg)
                        begin
                            hint_next = idx_reg + 1'b1;
                        end
                        if (idx_reg >= end_reg)
                        begin
                            end_next = idx_reg + 1'b1;
                        end
                        if (rd_empty)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        pend_released_next = rd_data_reg;
                        pend_ref_next      = 1'b1;
                    end
                    ACT_GET:
                    begin
                        if (rd_empty)
                        begin
                            pend_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            pend_found_next = rd_data_reg;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (rd_empty)
                        begin
                            pend_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            pend_released_next = rd_data_reg;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            if (idx_reg < hint_reg)
                            begin
                                hint_next = idx_reg;
                            end
                            // freed the last used slot: walk the end mark down
                            if (idx_reg + 1'b1 == end_reg)
                            begin
                                end_next   = idx_reg;
                                state_next = S_TRAIL_TEST;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_TRAIL_TEST:
            begin
                if (end_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = end_reg - 1'b1;
                    state_next = S_TRAIL_READ;
                end
            end
            S_TRAIL_READ:
            begin
                state_next = S_TRAIL_CHECK;
            end
            S_TRAIL_CHECK:
            begin
                if (rd_empty)
                begin
                    end_next   = idx_reg;
                    state_next = S_TRAIL_TEST;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = pend_status_reg;
                    out_index_next    = pend_index_reg;
                    out_found_next    = pend_found_reg;
                    out_released_next = pend_released_reg;
                    out_ref_next      = pend_ref_reg;
                    out_count_next    = count_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake and store write controls
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = obj_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_ALLOC_TEST:
            begin
                mem_we = scan_done && (idx_reg < CNT_W'(MAX_ENTRIES));
            end
            S_CHECK:
            begin
                unique case (act_reg)
                    ACT_ALLOC:   mem_we = rd_empty;
                    ACT_SET:     mem_we = 1'b1;
                    ACT_RELEASE:
                    begin
                        mem_we    = !rd_empty;
                        mem_wdata = '0;
                    end
                    default:     mem_we = 1'b0;
                endcase
            end
            S_READ, S_TRAIL_TEST, S_TRAIL_READ, S_TRAIL_CHECK, S_FINISH:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign result_index    = out_index_reg;
    assign found_object    = out_found_reg;
    assign released_object = out_released_reg;
    assign ref_taken       = out_ref_reg;
    assign used_count      = out_count_reg;

endmodule

`default_nettype wire

// ===== rtl/lfht_checker.sv =====
// port-level checks for the handle table, bound to the top level
`default_nettype none

`include "lowest_free_handle_table_defines.svh"

module lfht_checker
    import lfht_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [IDX_W-1:0]    result_index,
    input wire logic [OBJ_W-1:0]    found_object,
    input wire logic [OBJ_W-1:0]    released_object,
    input wire logic                ref_taken,
    input wire logic [CNT_W-1:0]    used_count
);

    // a stalled result holds
    `LFHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(used_count) && $stable(found_object),
        "result changed while stalled")

    // a failed command stores nothing and grants no handle
    `LFHT_ASSERT_NOW(a_fail_quiet, out_valid && (status != ST_OK),
        !ref_taken && (result_index == '0) && (found_object == '0),
        "failed command reported side effects")

    // storing an object leaves at least one slot occupied
    `LFHT_ASSERT_NOW(a_ref_count, out_valid && ref_taken,
        (status == ST_OK) && (used_count != '0) && (found_object == '0),
        "stored object with empty table")

    // a get result carries no release or grant
    `LFHT_ASSERT_NOW(a_found_only, out_valid && (found_object != '0),
        (released_object == '0) && !ref_taken && (used_count != '0),
        "found object mixed with other effects")

    // used count never exceeds the table
    `LFHT_ASSERT_NOW(a_count_range, out_valid,
        used_count <= CNT_W'(MAX_ENTRIES),
        "used count beyond capacity")

endmodule

bind lowest_free_handle_table lfht_checker u_lfht_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .result_index    (result_index),
    .found_object    (found_object),
    .released_object (released_object),
    .ref_taken       (ref_taken),
    .used_count      (used_count)
);

`default_nettype wire
